// ----- hdl/spk_pkg.sv -----
// ----------------------------------------------------------------------------
// spk_pkg
// shared constants, types and rotate helpers for the speck128/128 core
// ----------------------------------------------------------------------------
package spk_pkg;

  localparam int WORD_W = 64;
  localparam int ROUNDS = 32;
  localparam int RND_W  = (ROUNDS > 1) ? $clog2(ROUNDS) : 1;
  localparam int ROT_A  = 8;
  localparam int ROT_B  = 3;

  localparam int CFG_IDX_W = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_KEY_ROUND = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_SCHED = CFG_IDX_W'(1);

  localparam logic ACT_ENCRYPT = 1'b0;
  localparam logic ACT_DECRYPT = 1'b1;

  localparam logic [RND_W-1:0] RND_LAST = RND_W'(ROUNDS - 1);

  typedef logic [WORD_W-1:0] word_t;

  typedef enum logic [1:0] {
    ST_EXPAND,
    ST_IDLE,
    ST_RUN,
    ST_HOLD
  } state_t;

  function automatic word_t rot_r(input word_t v, input int s);
    rot_r = (v >> s) | (v << (WORD_W - s));
  endfunction

  function automatic word_t rot_l(input word_t v, input int s);
    rot_l = (v << s) | (v >> (WORD_W - s));
  endfunction

endpackage

// ----- hdl/speck128_128_block_cipher_top.sv -----
// ----------------------------------------------------------------------------
// speck128_128_block_cipher_top
// iterative speck128/128 core, one round per cycle on a shared round unit
// ----------------------------------------------------------------------------
// usage
//   cfg port: cfg_we writes cfg_data to register cfg_index (0 = key word k0,
//   1 = key word l0); other indexes are ignored. each key write restarts the
//   key schedule, which runs on the round unit and fills the round key ram
//   one word per cycle; in_stall is high meanwhile.
//   input channel: in_valid / in_stall carry in_action (0 encrypt, 1 decrypt)
//   and the block words. a word is taken only when the core is idle.
//   output channel: out_valid / out_stall carry out_high / out_low from an
//   output register.
//   the result is registered in the output register after the last round if
//   that register is free (one round per cycle, bounded by the single round
//   unit and the registered read of the key ram, which is fetched one round ahead).
//   a new word is accepted only once the previous one has run all rounds;
//   the next word is accepted while the previous result still waits. if the
//   output register is still full at the last round, the core holds the
//   result internally until the register frees up.
//   reset: key words clear to zero and the schedule of the zero key is
//   expanded before the first word is accepted.
// ----------------------------------------------------------------------------
module speck128_128_block_cipher_top (
  input  logic                           clk,
  input  logic                           rst_n,
  // configuration
  input  logic                           cfg_we,
  input  logic [spk_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [spk_pkg::WORD_W-1:0]     cfg_data,
  // input channel
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_action,
  input  logic [spk_pkg::WORD_W-1:0]     in_block_high,
  input  logic [spk_pkg::WORD_W-1:0]     in_block_low,
  // result channel
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [spk_pkg::WORD_W-1:0]     out_high,
  output logic [spk_pkg::WORD_W-1:0]     out_low
);

  // key registers
  spk_pkg::word_t key_round_word_r, key_round_word_nxt;
  spk_pkg::word_t key_schedule_word_r, key_schedule_word_nxt;

  // sequencer
  spk_pkg::state_t              state_r, state_nxt;
  logic [spk_pkg::RND_W-1:0]    cnt_r, cnt_nxt;
  logic                         action_r, action_nxt;

  // working words: block x/y during a run, l/k during key expansion
  spk_pkg::word_t x_r, x_nxt;
  spk_pkg::word_t y_r, y_nxt;

  // result register
  logic           out_valid_r, out_valid_nxt;
  spk_pkg::word_t out_high_r, out_high_nxt;
  spk_pkg::word_t out_low_r, out_low_nxt;

  // round unit and key ram
  logic                      rnd_decrypt;
  spk_pkg::word_t            rnd_key;
  spk_pkg::word_t            rnd_x;
  spk_pkg::word_t            rnd_y;
  spk_pkg::word_t            rk_rdata;
  logic                      rk_we;
  logic [spk_pkg::RND_W-1:0] rk_raddr;
  logic [spk_pkg::RND_W-1:0] fetch_idx;
  logic                      fetch_act;

  logic in_acc;
  logic out_acc;
  logic slot_free;
  logic key_wr;

  assign in_stall  = (state_r != spk_pkg::ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_acc   = out_valid_r && !out_stall;
  // output register is empty or drains this cycle
  assign slot_free = !out_valid_r || !out_stall;
  assign key_wr    = cfg_we && (cfg_index == spk_pkg::CFG_KEY_ROUND ||
                                cfg_index == spk_pkg::CFG_KEY_SCHED);

  // key fetch runs one round ahead of the round unit
  assign fetch_act = (state_r == spk_pkg::ST_IDLE) ? in_action : action_r;
  assign fetch_idx = (state_r == spk_pkg::ST_IDLE) ? '0 : cnt_r + 1'b1;
  assign rk_raddr  = (fetch_act == spk_pkg::ACT_DECRYPT) ?
                     spk_pkg::RND_LAST - fetch_idx : fetch_idx;

  // expansion writes k (held in y_r) at the current round index
  assign rk_we = (state_r == spk_pkg::ST_EXPAND) && !key_wr;

  spk_ram #(
    .WIDTH (spk_pkg::WORD_W),
    .DEPTH (spk_pkg::ROUNDS),
    .AW    (spk_pkg::RND_W)
  ) u_rk_ram (
    .clk   (clk),
    .we    (rk_we),
    .waddr (cnt_r),
    .wdata (y_r),
    .raddr (rk_raddr),
    .rdata (rk_rdata)
  );

  // schedule step is a forward round with l as x, k as y and the index as key
  assign rnd_decrypt = (state_r == spk_pkg::ST_EXPAND) ? spk_pkg::ACT_ENCRYPT : action_r;
  assign rnd_key     = (state_r == spk_pkg::ST_EXPAND) ?
                       spk_pkg::word_t'(cnt_r) : rk_rdata;

  spk_round u_round (
    .decrypt (rnd_decrypt),
    .x_in    (x_r),
    .y_in    (y_r),
    .rkey    (rnd_key),
    .x_out   (rnd_x),
    .y_out   (rnd_y)
  );

  always_comb begin
    state_nxt             = state_r;
    cnt_nxt               = cnt_r;
    action_nxt            = action_r;
    x_nxt                 = x_r;
    y_nxt                 = y_r;
    key_round_word_nxt    = key_round_word_r;
    key_schedule_word_nxt = key_schedule_word_r;
    out_valid_nxt         = out_valid_r && !out_acc;
    out_high_nxt          = out_high_r;
    out_low_nxt           = out_low_r;

    unique case (state_r)
      spk_pkg::ST_EXPAND: begin
        x_nxt   = rnd_x;
        y_nxt   = rnd_y;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == spk_pkg::RND_LAST) begin
          cnt_nxt   = '0;
          state_nxt = spk_pkg::ST_IDLE;
        end
      end
      spk_pkg::ST_IDLE: begin
        if (in_acc) begin
          action_nxt = in_action;
          x_nxt      = in_block_high;
          y_nxt      = in_block_low;
          cnt_nxt    = '0;
          state_nxt  = spk_pkg::ST_RUN;
        end
      end
      spk_pkg::ST_RUN: begin
        x_nxt   = rnd_x;
        y_nxt   = rnd_y;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == spk_pkg::RND_LAST) begin
          cnt_nxt = '0;
          if (slot_free) begin
            out_valid_nxt = 1'b1;
            out_high_nxt  = rnd_x;
            out_low_nxt   = rnd_y;
            state_nxt     = spk_pkg::ST_IDLE;
          end else begin
            state_nxt = spk_pkg::ST_HOLD;
          end
        end
      end
      spk_pkg::ST_HOLD: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_high_nxt  = x_r;
          out_low_nxt   = y_r;
          state_nxt     = spk_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = spk_pkg::ST_EXPAND;
        cnt_nxt   = '0;
      end
    endcase

    // key write restarts the schedule from the new key words
    if (key_wr) begin
      if (cfg_index == spk_pkg::CFG_KEY_ROUND) begin
        key_round_word_nxt = cfg_data;
      end else begin
        key_schedule_word_nxt = cfg_data;
      end
      x_nxt     = key_schedule_word_nxt;
      y_nxt     = key_round_word_nxt;
      cnt_nxt   = '0;
      state_nxt = spk_pkg::ST_EXPAND;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r             <= spk_pkg::ST_EXPAND;
      cnt_r               <= '0;
      action_r            <= spk_pkg::ACT_ENCRYPT;
      key_round_word_r    <= '0;
      key_schedule_word_r <= '0;
      x_r                 <= '0;
      y_r                 <= '0;
      out_valid_r         <= 1'b0;
    end else begin
      state_r             <= state_nxt;
      cnt_r               <= cnt_nxt;
      action_r            <= action_nxt;
      key_round_word_r    <= key_round_word_nxt;
      key_schedule_word_r <= key_schedule_word_nxt;
      x_r                 <= x_nxt;
      y_r                 <= y_nxt;
      out_valid_r         <= out_valid_nxt;
    end
    out_high_r <= out_high_nxt;
    out_low_r  <= out_low_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_high  = out_high_r;
  assign out_low   = out_low_r;

`ifndef SYNTHESIS
  // an accepted word starts the run at round zero
  a_accept_starts_run: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && !key_wr |=> state_r == spk_pkg::ST_RUN && cnt_r == '0)
    else $error("accepted word did not start a run");

  // last round with a free output slot loads the result register
  a_last_round_delivers: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == spk_pkg::ST_RUN && cnt_r == spk_pkg::RND_LAST && slot_free && !key_wr
    |=> out_valid_r && state_r == spk_pkg::ST_IDLE)
    else $error("last round did not deliver a result");

  // a key write always restarts expansion
  a_key_write_expands: assert property (@(posedge clk) disable iff (!rst_n)
    key_wr |=> state_r == spk_pkg::ST_EXPAND && cnt_r == '0)
    else $error("key write did not restart the schedule");

  // a held result is never dropped while the output register is full
  a_hold_keeps_result: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == spk_pkg::ST_HOLD && !slot_free && !key_wr
    |=> state_r == spk_pkg::ST_HOLD && $stable(x_r) && $stable(y_r))
    else $error("held result lost");
`endif

endmodule

// ----- hdl/spk_ram.sv -----
// ----------------------------------------------------------------------------
// spk_ram
// generic single write port ram with registered read
// ----------------------------------------------------------------------------
module spk_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 32,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- hdl/spk_round.sv -----
// ----------------------------------------------------------------------------
// spk_round
// one speck round, forward or inverse; also serves the key schedule step
// ----------------------------------------------------------------------------
module spk_round (
  input  logic          decrypt,
  input  spk_pkg::word_t x_in,
  input  spk_pkg::word_t y_in,
  input  spk_pkg::word_t rkey,
  output spk_pkg::word_t x_out,
  output spk_pkg::word_t y_out
);

  spk_pkg::word_t enc_x;
  spk_pkg::word_t enc_y;
  spk_pkg::word_t dec_x;
  spk_pkg::word_t dec_y;

  // forward: x = (ror(x,8) + y) ^ k, y = rol(y,3) ^ x
  assign enc_x = (spk_pkg::rot_r(x_in, spk_pkg::ROT_A) + y_in) ^ rkey;
  assign enc_y = spk_pkg::rot_l(y_in, spk_pkg::ROT_B) ^ enc_x;

  // inverse: y = ror(x ^ y, 3), x = rol((x ^ k) - y, 8)
  assign dec_y = spk_pkg::rot_r(x_in ^ y_in, spk_pkg::ROT_B);
  assign dec_x = spk_pkg::rot_l((x_in ^ rkey) - dec_y, spk_pkg::ROT_A);

  assign x_out = decrypt ? dec_x : enc_x;
  assign y_out = decrypt ? dec_y : enc_y;

endmodule

// ----- tb/sv/speck128_128_block_cipher_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// speck128_128_block_cipher_checker
// tracks the key registers, predicts every result word of the speck128/128
// core and compares it field by field with what the result channel delivers
// ----------------------------------------------------------------------------
module speck128_128_block_cipher_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [spk_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [spk_pkg::WORD_W-1:0]     cfg_data,
  input  logic                           in_valid,
  input  logic                           in_stall,
  input  logic                           in_action,
  input  logic [spk_pkg::WORD_W-1:0]     in_block_high,
  input  logic [spk_pkg::WORD_W-1:0]     in_block_low,
  input  logic                           out_valid,
  input  logic                           out_stall,
  input  logic [spk_pkg::WORD_W-1:0]     out_high,
  input  logic [spk_pkg::WORD_W-1:0]     out_low,
  output int                             pending,
  output int                             errors
);

  typedef struct packed {
    spk_pkg::word_t hi;
    spk_pkg::word_t lo;
  } block_t;

  spk_pkg::word_t key_k0;
  spk_pkg::word_t key_l0;
  spk_pkg::word_t round_key [spk_pkg::ROUNDS];
  block_t         cipher_q [$];

  function automatic spk_pkg::word_t ror_a(input spk_pkg::word_t v);
    return {v[spk_pkg::ROT_A-1:0], v[spk_pkg::WORD_W-1:spk_pkg::ROT_A]};
  endfunction

  function automatic spk_pkg::word_t rol_b(input spk_pkg::word_t v);
    return {v[spk_pkg::WORD_W-spk_pkg::ROT_B-1:0],
            v[spk_pkg::WORD_W-1:spk_pkg::WORD_W-spk_pkg::ROT_B]};
  endfunction

  function automatic void expand_round_keys();
    spk_pkg::word_t kw;
    spk_pkg::word_t lw;
    int             r;
    kw = key_k0;
    lw = key_l0;
    round_key[0] = kw;
    for (r = 0; r < spk_pkg::ROUNDS - 1; r++) begin
      lw = (kw + ror_a(lw)) ^ spk_pkg::word_t'(r);
      kw = rol_b(kw) ^ lw;
      round_key[r+1] = kw;
    end
  endfunction

  function automatic block_t speck_transform(input logic act,
                                             input spk_pkg::word_t xi,
                                             input spk_pkg::word_t yi);
    spk_pkg::word_t x;
    spk_pkg::word_t y;
    int             r;
    x = xi;
    y = yi;
    if (act == spk_pkg::ACT_ENCRYPT) begin
      for (r = 0; r < spk_pkg::ROUNDS; r++) begin
        x = (ror_a(x) + y) ^ round_key[r];
        y = rol_b(y) ^ x;
      end
    end else begin
      // inverse rounds, last key first
      for (r = spk_pkg::ROUNDS - 1; r >= 0; r--) begin
        y = x ^ y;
        y = {y[spk_pkg::ROT_B-1:0], y[spk_pkg::WORD_W-1:spk_pkg::ROT_B]};
        x = (x ^ round_key[r]) - y;
        x = {x[spk_pkg::WORD_W-spk_pkg::ROT_A-1:0],
             x[spk_pkg::WORD_W-1:spk_pkg::WORD_W-spk_pkg::ROT_A]};
      end
    end
    return {x, y};
  endfunction

  task automatic report_mismatch(input string what, input spk_pkg::word_t got,
                                 input spk_pkg::word_t want);
    $display("%0t ns: %s: got %h, expected %h", $time, what, got, want);
    errors++;
  endtask

  initial begin
    errors  = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    block_t want;
    if (!rst_n) begin
      key_k0 = '0;
      key_l0 = '0;
      expand_round_keys();
      cipher_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          spk_pkg::CFG_KEY_ROUND: begin
            key_k0 = cfg_data;
            expand_round_keys();
          end
          spk_pkg::CFG_KEY_SCHED: begin
            key_l0 = cfg_data;
            expand_round_keys();
          end
          default: ;  // unused index, no effect
        endcase
      end
      if (in_valid && !in_stall)
        cipher_q.push_back(speck_transform(in_action, in_block_high, in_block_low));
      if (out_valid && !out_stall) begin
        if (cipher_q.size() == 0) begin
          report_mismatch("result word with nothing pending", out_high, '0);
        end else begin
          want = cipher_q.pop_front();
          if (out_high !== want.hi) report_mismatch("out_high", out_high, want.hi);
          if (out_low !== want.lo) report_mismatch("out_low", out_low, want.lo);
        end
      end
    end
    pending = cipher_q.size();
  end

endmodule

// ----- tb/sv/speck128_128_block_cipher_top_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// speck128_128_block_cipher_top_tb
// drives blocks through the speck128/128 core under changing keys; a checker
// beside the core predicts and compares every result word
// ----------------------------------------------------------------------------
module speck128_128_block_cipher_top_tb;

  localparam int N_RANDOM     = 2000;
  localparam int PHASES       = 8;
  localparam int HOLD_CYCLES  = 400;  // long receiver hold-off
  localparam int DRAIN_CYCLES = 40;   // quiet wait after the last result word
  localparam int TIMEOUT_NS   = 20_000_000;

  typedef logic [spk_pkg::CFG_IDX_W-1:0] cfg_idx_t;

  // clock and reset
  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  // config port
  logic           cfg_we    = 1'b0;
  cfg_idx_t       cfg_index = '0;
  spk_pkg::word_t cfg_data  = '0;

  // input channel
  logic           in_valid      = 1'b0;
  logic           in_stall;
  logic           in_action     = spk_pkg::ACT_ENCRYPT;
  spk_pkg::word_t in_block_high = '0;
  spk_pkg::word_t in_block_low  = '0;

  // result channel
  logic           out_valid;
  logic           out_stall = 1'b0;
  spk_pkg::word_t out_high;
  spk_pkg::word_t out_low;

  // checker status
  int pending;
  int errors;

  // idle rate in percent, shared by both sides; zero turns idling off
  int idle_pct  = 20;
  bit long_hold = 1'b0;
  bit hold_done = 1'b0;

  // run statistics for the summary
  int n_enc  = 0;
  int n_dec  = 0;
  int n_keys = 0;

  speck128_128_block_cipher_top i_dut (.*);

  speck128_128_block_cipher_checker i_chk (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // mostly random content, with the all-zero and all-one words mixed in
  function automatic spk_pkg::word_t pick_word();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // offer one word, optionally after a gap; returns at the accepting edge
  // and leaves in_valid high so back-to-back words need no second update
  task automatic send_block(input logic act, input spk_pkg::word_t hi,
                            input spk_pkg::word_t lo);
    if ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 40)) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_action     <= act;
    in_block_high <= hi;
    in_block_low  <= lo;
    // in_stall only moves on a rising edge, so the falling edge shows
    // what the next rising edge will see
    @(negedge clk);
    while (in_stall) @(negedge clk);
    @(posedge clk);
    if (act == spk_pkg::ACT_ENCRYPT) n_enc++;
    else n_dec++;
  endtask

  // wait until every expected word is back and the core has gone quiet
  task automatic drain_core();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // one register write per edge; the caller lowers cfg_we after a batch
  task automatic cfg_write(input cfg_idx_t idx, input spk_pkg::word_t val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
  endtask

  task automatic load_key(input spk_pkg::word_t k0, input spk_pkg::word_t l0);
    drain_core();
    cfg_write(spk_pkg::CFG_KEY_ROUND, k0);
    cfg_write(spk_pkg::CFG_KEY_SCHED, l0);
    cfg_we <= 1'b0;
    n_keys++;
  endtask

  // receiver: random short stalls, occasional bursts, one long hold-off
  initial begin : rx_side
    forever begin
      @(posedge clk);
      if (long_hold && !hold_done) begin
        // hold long enough for the output register and the internal
        // holding slot to fill, so the core pushes back on its input
        hold_done = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if ($urandom_range(0, 1999) < idle_pct) begin
        // burst long enough to catch the core at its last round
        out_stall <= 1'b1;
        repeat ($urandom_range(5, 40)) @(posedge clk);
      end
      out_stall <= ($urandom_range(0, 399) < idle_pct);
    end
  end

  initial begin : stimulus
    int ph;
    int i;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // ------------------------------------------------------------------
    // directed part
    // ------------------------------------------------------------------

    // zero key left by reset; the core expands it before the first word
    n_keys = 1;
    send_block(spk_pkg::ACT_ENCRYPT, '0, '0);
    send_block(spk_pkg::ACT_DECRYPT, '0, '0);
    send_block(spk_pkg::ACT_ENCRYPT, '1, '1);
    send_block(spk_pkg::ACT_DECRYPT, '1, '1);

    // published key, plus writes to unused indexes that must change nothing
    drain_core();
    cfg_write(spk_pkg::CFG_KEY_ROUND, 64'h0706050403020100);
    cfg_write(spk_pkg::CFG_KEY_SCHED, 64'h0f0e0d0c0b0a0908);
    cfg_write(cfg_idx_t'(2), '1);
    cfg_write('1, '1);
    cfg_we <= 1'b0;
    n_keys++;
    send_block(spk_pkg::ACT_ENCRYPT, 64'h6c61766975716520, 64'h7469206564616d20);
    send_block(spk_pkg::ACT_DECRYPT, 64'ha65d985179783265, 64'h7860fedf5c570d18);
    send_block(spk_pkg::ACT_ENCRYPT, 64'h8000000000000000, 64'h0000000000000001);
    send_block(spk_pkg::ACT_DECRYPT, 64'h0000000000000001, 64'h8000000000000000);
    send_block(spk_pkg::ACT_ENCRYPT, 64'h5555555555555555, 64'haaaaaaaaaaaaaaaa);
    send_block(spk_pkg::ACT_DECRYPT, 64'haaaaaaaaaaaaaaaa, 64'h5555555555555555);

    // key word extremes
    load_key('1, '1);
    send_block(spk_pkg::ACT_ENCRYPT, '0, '1);
    send_block(spk_pkg::ACT_DECRYPT, '1, '0);
    send_block(spk_pkg::ACT_ENCRYPT, '1, '1);
    send_block(spk_pkg::ACT_DECRYPT, '0, '0);

    load_key('1, '0);
    send_block(spk_pkg::ACT_ENCRYPT, '0, '0);
    send_block(spk_pkg::ACT_DECRYPT, '0, '0);

    load_key('0, '1);
    send_block(spk_pkg::ACT_ENCRYPT, '1, '1);
    send_block(spk_pkg::ACT_DECRYPT, '1, '1);

    // ------------------------------------------------------------------
    // random part: one key setting per phase
    // ------------------------------------------------------------------
    for (ph = 0; ph < PHASES; ph++) begin
      drain_core();
      // write the key words in either order, sometimes only one of them
      case ($urandom_range(0, 3))
        0: cfg_write(spk_pkg::CFG_KEY_ROUND, pick_word());
        1: cfg_write(spk_pkg::CFG_KEY_SCHED, pick_word());
        2: begin
          cfg_write(spk_pkg::CFG_KEY_SCHED, pick_word());
          cfg_write(spk_pkg::CFG_KEY_ROUND, pick_word());
        end
        default: begin
          cfg_write(spk_pkg::CFG_KEY_ROUND, pick_word());
          cfg_write(spk_pkg::CFG_KEY_SCHED, pick_word());
        end
      endcase
      if ($urandom_range(0, 3) == 0)
        cfg_write(cfg_idx_t'($urandom_range(2, 255)), pick_word());
      cfg_we <= 1'b0;
      n_keys++;

      // phase 2 carries the long receiver hold, phase 4 runs without idling
      idle_pct = (ph == 4) ? 0 : 20;
      if (ph == 2) long_hold = 1'b1;

      for (i = 0; i < N_RANDOM / PHASES; i++)
        send_block(logic'($urandom_range(0, 1)), pick_word(), pick_word());
    end

    // let everything come back and the core go quiet
    idle_pct = 20;
    drain_core();

    $display("ran %0d blocks (%0d encrypt, %0d decrypt) under %0d key settings",
             n_enc + n_dec, n_enc, n_dec, n_keys);
    $display("incl. unused config indexes, a %0d-cycle receiver hold and a no-idle phase",
             HOLD_CYCLES);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // watchdog
  initial begin
    #(TIMEOUT_NS);
    $display("timed out with %0d result words outstanding", pending);
    $display("Regression FAIL");
    $finish;
  end

endmodule

// ----- speck128_128_block_cipher_top.f -----
hdl/spk_pkg.sv
hdl/spk_ram.sv
hdl/spk_round.sv
hdl/speck128_128_block_cipher_top.sv
tb/sv/speck128_128_block_cipher_checker.sv
tb/sv/speck128_128_block_cipher_top_tb.sv
